// ----- design/stereo_biquad_cascade_eq_macros.svh -----
// Assertion macros shared by the equalizer checker.
`ifndef STEREO_BIQUAD_CASCADE_EQ_MACROS_SVH
`define STEREO_BIQUAD_CASCADE_EQ_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SBQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked on the next rising clock edge.
`define SBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sbq_pkg.sv -----
// Types, codes and arithmetic helpers of the stereo biquad equalizer.
package sbq_pkg;

    localparam int COEF_W = 32;
    localparam int DATA_W = 32;
    localparam int SAMP_W = 24;
    localparam int BAND_W = 6;
    localparam int PROD_W = 64;
    localparam int RND_W  = 38;
    localparam int ACC_W  = 40;

    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_DISABLE = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } sbq_coef_t;

    typedef struct packed {
        logic                     coef_we;
        logic                     delay_we;
        logic                     clear_we;
        logic                     ch;
        logic [BAND_W-1:0]        band;
        sbq_coef_t                coef;
        logic signed [DATA_W-1:0] z1;
        logic signed [DATA_W-1:0] z2;
    } sbq_wr_t;

    typedef struct packed {
        logic              rd_en;
        logic              ch;
        logic [BAND_W-1:0] band;
    } sbq_rd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD,
        ST_MB0,
        ST_Y,
        ST_A1,
        ST_B2,
        ST_A2,
        ST_WB,
        ST_OUT
    } sbq_state_t;

    // True when a wide sum does not fit in 32 signed bits.
    function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
        return (v > ACC_W'(64'sh7FFFFFFF)) || (v < -ACC_W'(64'sh80000000));
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > ACC_W'(64'sh7FFFFFFF)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -ACC_W'(64'sh80000000)) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/stereo_biquad_cascade_eq.sv -----
// Top level of the stereo cascaded biquad equalizer: sequencer and datapath.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | kind, channel, sample_in, band_index,
//          |                      | coef_b0..coef_a2, end_of_block
//  out     | out_valid / out_ready| sample_out, channel_out, block_end_out,
//          |                      | clipped
//
// A load or disable transfer leaves the block idle and the input stays ready.
// A sample scans every band in turn; for each active band the states RD, MB0, Y,
// A1, B2, A2 and WB do the memory read, the five products on the one shared
// multiplier and the delay write-back, then a final scan and the output load.
// Reset clears the active mask, the delay valid bits and the output valid bit.
// A finished result waits in the output register; the next item is taken while
// it waits, and a second finished sample stalls until the first one is taken.
module stereo_biquad_cascade_eq
    import sbq_pkg::*;
#(
    parameter int BANDS    = 64,
    parameter int CHANNELS = 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic                     channel,
    input  logic signed [SAMP_W-1:0] sample_in,
    input  logic [BAND_W-1:0]        band_index,
    input  logic signed [COEF_W-1:0] coef_b0,
    input  logic signed [COEF_W-1:0] coef_b1,
    input  logic signed [COEF_W-1:0] coef_b2,
    input  logic signed [COEF_W-1:0] coef_a1,
    input  logic signed [COEF_W-1:0] coef_a2,
    input  logic                     end_of_block,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SAMP_W-1:0] sample_out,
    output logic                     channel_out,
    output logic                     block_end_out,
    output logic                     clipped
);

    localparam int BW  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int BCW = $clog2(BANDS + 1);

    sbq_state_t               state_reg, state_next;
    logic [BANDS-1:0]         active_reg, active_next;
    logic [BCW-1:0]           band_reg, band_next;
    logic                     ch_reg, ch_next;
    logic                     eob_reg, eob_next;
    logic                     clip_reg, clip_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] y_reg, y_next;
    logic signed [ACC_W-1:0]  acc1_reg, acc1_next;
    logic signed [ACC_W-1:0]  acc2_reg, acc2_next;
    logic                     out_valid_reg;
    logic signed [SAMP_W-1:0] out_sample_reg;
    logic                     out_ch_reg;
    logic                     out_eob_reg;
    logic                     out_clip_reg;
    logic                     load_out;

    sbq_rd_t                  rd;
    sbq_wr_t                  wr;
    sbq_coef_t                coef_q;
    logic signed [DATA_W-1:0] z1_q;
    logic signed [DATA_W-1:0] z2_q;
    logic signed [COEF_W-1:0] mac_coef;
    logic signed [DATA_W-1:0] mac_value;
    logic signed [RND_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  y_sum;
    logic signed [ACC_W-1:0]  z2_sum;
    logic                     in_xfer;
    logic                     band_ok;
    logic                     ch_ok;

    sbq_store #(
        .BANDS    (BANDS),
        .CHANNELS (CHANNELS)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (rd),
        .wr     (wr),
        .coef_q (coef_q),
        .z1_q   (z1_q),
        .z2_q   (z2_q)
    );

    sbq_mac u_mac (
        .clk     (clk),
        .coef    (mac_coef),
        .value   (mac_value),
        .rounded (rnd)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign band_ok  = (int'(band_index) < BANDS);
    assign ch_ok    = (int'(channel) < CHANNELS);

    // The multiplier operands follow the state; each registered product is used by the state after it.
    always_comb begin
        mac_coef  = coef_q.b0;
        mac_value = x_reg;
        case (state_reg)
            ST_Y:    begin mac_coef = coef_q.b1; mac_value = x_reg; end
            ST_A1:   begin mac_coef = coef_q.a1; mac_value = y_reg; end
            ST_B2:   begin mac_coef = coef_q.b2; mac_value = x_reg; end
            ST_A2:   begin mac_coef = coef_q.a2; mac_value = y_reg; end
            default: begin mac_coef = coef_q.b0; mac_value = x_reg; end
        endcase
    end

    assign y_sum  = ACC_W'(rnd) + ACC_W'(z1_q);
    assign z2_sum = acc2_reg - ACC_W'(rnd);

    always_comb begin
        state_next  = state_reg;
        active_next = active_reg;
        band_next   = band_reg;
        ch_next     = ch_reg;
        eob_next    = eob_reg;
        clip_next   = clip_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        acc1_next   = acc1_reg;
        acc2_next   = acc2_reg;
        load_out    = 1'b0;
        rd          = '0;
        wr          = '0;
        rd.ch       = ch_reg;
        rd.band     = BAND_W'(band_reg[BW-1:0]);
        wr.ch       = ch_reg;
        wr.band     = BAND_W'(band_reg[BW-1:0]);
        wr.coef     = '{coef_b0, coef_b1, coef_b2, coef_a1, coef_a2};
        wr.z1       = sat32(acc1_reg);
        wr.z2       = sat32(z2_sum);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (kind == KIND_LOAD && band_ok) begin
                        wr.coef_we = 1'b1;
                        wr.band    = band_index;
                        active_next[band_index[BW-1:0]] = 1'b1;
                    end else if (kind == KIND_DISABLE && band_ok) begin
                        wr.clear_we = 1'b1;
                        wr.band     = band_index;
                        active_next[band_index[BW-1:0]] = 1'b0;
                    end else if (kind == KIND_SAMPLE && ch_ok) begin
                        ch_next    = channel;
                        eob_next   = end_of_block;
                        clip_next  = 1'b0;
                        x_next     = DATA_W'(sample_in);
                        band_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (band_reg == BCW'(BANDS)) begin
                    state_next = ST_OUT;
                end else if (active_reg[band_reg[BW-1:0]]) begin
                    state_next = ST_RD;
                end else begin
                    band_next = band_reg + BCW'(1);
                end
            end
            ST_RD: begin
                rd.rd_en   = 1'b1;
                state_next = ST_MB0;
            end
            ST_MB0: begin
                state_next = ST_Y;
            end
            ST_Y: begin
                y_next     = sat32(y_sum);
                clip_next  = clip_reg | ovf32(y_sum);
                state_next = ST_A1;
            end
            ST_A1: begin
                acc1_next  = ACC_W'(rnd) + ACC_W'(z2_q);
                state_next = ST_B2;
            end
            ST_B2: begin
                acc1_next  = acc1_reg - ACC_W'(rnd);
                state_next = ST_A2;
            end
            ST_A2: begin
                acc2_next  = ACC_W'(rnd);
                state_next = ST_WB;
            end
            ST_WB: begin
                wr.delay_we = 1'b1;
                clip_next   = clip_reg | ovf32(acc1_reg) | ovf32(z2_sum);
                x_next      = y_reg;
                band_next   = band_reg + BCW'(1);
                state_next  = ST_SCAN;
            end
            ST_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            band_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
            band_reg   <= band_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        ch_reg   <= ch_next;
        eob_reg  <= eob_next;
        clip_reg <= clip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc1_reg <= acc1_next;
        acc2_reg <= acc2_next;
        if (load_out) begin
            // The final value is saturated to the 24-bit output range.
            if (x_reg > DATA_W'(32'sh007FFFFF)) begin
                out_sample_reg <= 24'sh7FFFFF;
                out_clip_reg   <= 1'b1;
            end else if (x_reg < -DATA_W'(32'sh00800000)) begin
                out_sample_reg <= 24'sh800000;
                out_clip_reg   <= 1'b1;
            end else begin
                out_sample_reg <= x_reg[SAMP_W-1:0];
                out_clip_reg   <= clip_reg;
            end
            out_ch_reg  <= ch_reg;
            out_eob_reg <= eob_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = out_sample_reg;
    assign channel_out   = out_ch_reg;
    assign block_end_out = out_eob_reg;
    assign clipped       = out_clip_reg;

endmodule

// ----- design/sbq_mac.sv -----
// Shared 32x32 multiplier with registered product and half-up rounding to Q14.23.
module sbq_mac
    import sbq_pkg::*;
(
    input  logic                     clk,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [DATA_W-1:0] value,
    output logic signed [RND_W-1:0]  rounded
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] biased;

    always_ff @(posedge clk) begin
        prod_reg <= PROD_W'(coef) * PROD_W'(value);
    end

    // Adding half an LSB and shifting right arithmetically rounds half up.
    assign biased  = prod_reg + (PROD_W'(1) <<< 25);
    assign rounded = RND_W'(biased >>> 26);

endmodule

// ----- design/sbq_store.sv -----
// Coefficient and delay memories with registered reads and delay valid bits.
module sbq_store
    import sbq_pkg::*;
#(
    parameter int BANDS    = 64,
    parameter int CHANNELS = 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sbq_rd_t                  rd,
    input  sbq_wr_t                  wr,
    output sbq_coef_t                coef_q,
    output logic signed [DATA_W-1:0] z1_q,
    output logic signed [DATA_W-1:0] z2_q
);

    localparam int ENTRIES = CHANNELS * BANDS;
    localparam int BW      = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    sbq_coef_t                coef_mem [BANDS];
    logic [2*DATA_W-1:0]      delay_mem [ENTRIES];
    logic [ENTRIES-1:0]       valid_reg;
    logic [2*DATA_W-1:0]      delay_rd_reg;
    logic                     valid_rd_reg;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;

    assign rd_addr = rd.ch ? AW'(BANDS) + AW'(rd.band[BW-1:0]) : AW'(rd.band[BW-1:0]);
    assign wr_addr = wr.ch ? AW'(BANDS) + AW'(wr.band[BW-1:0]) : AW'(wr.band[BW-1:0]);

    always_ff @(posedge clk) begin
        if (wr.coef_we) begin
            coef_mem[wr.band[BW-1:0]] <= wr.coef;
        end
        if (wr.delay_we) begin
            delay_mem[wr_addr] <= {wr.z1, wr.z2};
        end
        if (rd.rd_en) begin
            coef_q       <= coef_mem[rd.band[BW-1:0]];
            delay_rd_reg <= delay_mem[rd_addr];
        end
    end

    // An entry whose valid bit is low reads as zero; disable clears both channels.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end else begin
            if (rd.rd_en) begin
                valid_rd_reg <= valid_reg[rd_addr];
            end
            if (wr.delay_we) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (wr.clear_we) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    valid_reg[AW'(c * BANDS) + AW'(wr.band[BW-1:0])] <= 1'b0;
                end
            end
        end
    end

    assign z1_q = valid_rd_reg ? delay_rd_reg[2*DATA_W-1:DATA_W] : '0;
    assign z2_q = valid_rd_reg ? delay_rd_reg[DATA_W-1:0] : '0;

endmodule

// ----- design/sbq_checker.sv -----
// Port-level checker of the equalizer and its bind to the top level.
`include "stereo_biquad_cascade_eq_macros.svh"

module sbq_checker
    import sbq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [1:0]               kind,
    input logic                     channel,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [SAMP_W-1:0] sample_out
);

    `SBQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")
    `SBQ_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(sample_out), "sample_out changed while stalled")
    `SBQ_ASSERT_NEXT(a_sample_busy, clk, rst_n, in_valid && in_ready && kind == KIND_SAMPLE && channel == 1'b0, !in_ready, "input still ready after a sample transfer")
    `SBQ_ASSERT_IMP(a_result_after_busy, clk, rst_n, $rose(out_valid), $past(!in_ready), "result appeared without a busy period")

endmodule

bind stereo_biquad_cascade_eq sbq_checker u_sbq_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the stereo cascaded biquad equalizer.
`timescale 1ns / 100ps

module testbench;
    import sbq_pkg::*;

    localparam int NUM_BANDS  = 64;
    localparam int RAND_ITEMS = 1000;
    localparam int MAX_ACTIVE = 6;
    localparam int HOLD_LEN   = 3000;
    localparam int DRAIN_WAIT = 700;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // One input item together with an optional expectation that can be read
    // off directly: passthrough with no active band or a unity band, or hard saturation.
    typedef struct {
        logic [1:0]               kind;
        logic                     ch;
        logic signed [SAMP_W-1:0] smp;
        logic [BAND_W-1:0]        band;
        logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
        logic                     eob;
        bit                       typed;
        logic signed [SAMP_W-1:0] typed_smp;
        bit                       typed_clip;
    } eq_item_t;

    typedef struct {
        logic signed [SAMP_W-1:0] smp;
        logic                     ch;
        logic                     eob;
        logic                     clip;
    } eq_sample_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               kind;
    logic                     channel;
    logic signed [SAMP_W-1:0] sample_in;
    logic [BAND_W-1:0]        band_index;
    logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic                     end_of_block;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [SAMP_W-1:0] sample_out;
    logic                     channel_out;
    logic                     block_end_out;
    logic                     clipped;

    // Shadow of the equalizer state used by the filter predictor.
    bit                       band_on [NUM_BANDS];
    logic signed [COEF_W-1:0] shadow_b0 [NUM_BANDS];
    logic signed [COEF_W-1:0] shadow_b1 [NUM_BANDS];
    logic signed [COEF_W-1:0] shadow_b2 [NUM_BANDS];
    logic signed [COEF_W-1:0] shadow_a1 [NUM_BANDS];
    logic signed [COEF_W-1:0] shadow_a2 [NUM_BANDS];
    logic signed [DATA_W-1:0] shadow_z1 [2][NUM_BANDS];
    logic signed [DATA_W-1:0] shadow_z2 [2][NUM_BANDS];

    eq_sample_t pending_samples[$];
    eq_item_t   directed_items[$];
    int         errors;
    bit         hold_request;

    stereo_biquad_cascade_eq dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .channel      (channel),
        .sample_in    (sample_in),
        .band_index   (band_index),
        .coef_b0      (coef_b0),
        .coef_b1      (coef_b1),
        .coef_b2      (coef_b2),
        .coef_a1      (coef_a1),
        .coef_a2      (coef_a2),
        .end_of_block (end_of_block),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_out   (sample_out),
        .channel_out  (channel_out),
        .block_end_out(block_end_out),
        .clipped      (clipped)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Q5.26 coefficient times Q8.23 value, rounded half up to Q14.23.
    // The arithmetic right shift on a signed value is a floor division.
    function automatic longint scaled_product(input longint c, input longint v);
        longint p;
        p = c * v + (longint'(1) <<< 25);
        return p >>> 26;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                     inout bit clip);
        if (v > hi) begin
            clip = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Applies one accepted item to the shadow state. A sample walks every active
    // band in ascending order and yields the filtered output; other kinds only
    // update the coefficient store, the band mask or the delay state.
    function automatic bit filter_item(input eq_item_t it, output eq_sample_t res);
        longint x, y, z1, z2;
        bit     clip;
        res = '{default: 0};
        case (it.kind)
            KIND_LOAD: begin
                shadow_b0[it.band] = it.b0;
                shadow_b1[it.band] = it.b1;
                shadow_b2[it.band] = it.b2;
                shadow_a1[it.band] = it.a1;
                shadow_a2[it.band] = it.a2;
                band_on[it.band] = 1'b1;
                return 1'b0;
            end
            KIND_DISABLE: begin
                band_on[it.band] = 1'b0;
                for (int c = 0; c < 2; c++) begin
                    shadow_z1[c][it.band] = '0;
                    shadow_z2[c][it.band] = '0;
                end
                return 1'b0;
            end
            KIND_SAMPLE: begin
                clip = 1'b0;
                x = it.smp;
                for (int b = 0; b < NUM_BANDS; b++) begin
                    if (band_on[b]) begin
                        y = scaled_product(shadow_b0[b], x) + shadow_z1[it.ch][b];
                        y = clamp(y, -64'sd2147483648, 64'sd2147483647, clip);
                        z1 = scaled_product(shadow_b1[b], x) - scaled_product(shadow_a1[b], y)
                             + shadow_z2[it.ch][b];
                        z2 = scaled_product(shadow_b2[b], x) - scaled_product(shadow_a2[b], y);
                        shadow_z1[it.ch][b] =
                            DATA_W'(clamp(z1, -64'sd2147483648, 64'sd2147483647, clip));
                        shadow_z2[it.ch][b] =
                            DATA_W'(clamp(z2, -64'sd2147483648, 64'sd2147483647, clip));
                        x = y;
                    end
                end
                x = clamp(x, -64'sd8388608, 64'sd8388607, clip);
                res.smp  = x[SAMP_W-1:0];
                res.ch   = it.ch;
                res.eob  = it.eob;
                res.clip = clip;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Most gaps are short; a few are long enough to span a whole sample.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 250);
    endfunction

    function automatic void add_row(input int k, input int ch, input int smp, input int band,
                                    input int b0, input int b1, input int b2,
                                    input int a1, input int a2,
                                    input int eob, input int typed,
                                    input int typed_smp, input int typed_clip);
        eq_item_t it;
        it.kind       = 2'(k);
        it.ch         = 1'(ch);
        it.smp        = SAMP_W'(smp);
        it.band       = BAND_W'(band);
        it.b0         = b0;
        it.b1         = b1;
        it.b2         = b2;
        it.a1         = a1;
        it.a2         = a2;
        it.eob        = 1'(eob);
        it.typed      = 1'(typed);
        it.typed_smp  = SAMP_W'(typed_smp);
        it.typed_clip = 1'(typed_clip);
        directed_items.push_back(it);
    endfunction

    function automatic logic signed [COEF_W-1:0] random_coef(input int mode);
        case (mode)
            0:       return $signed(COEF_W'($urandom_range(0, 32'h03FF_FFFF))) - 32'sh0200_0000;
            1:       return $urandom();
            default: return ($urandom_range(1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    function automatic logic signed [SAMP_W-1:0] random_sample();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 24'sh7F_FFFF;
        if (r < 10) return 24'sh80_0000;
        if (r < 50) return $signed(SAMP_W'($urandom_range(0, 4095))) - 24'sd2048;
        return SAMP_W'($urandom());
    endfunction

    // Random item: mostly samples, with loads and disables that keep only a few
    // bands active so that each sample stays well below the worst-case latency.
    function automatic eq_item_t random_item();
        eq_item_t it;
        int       r, n_on, mode;
        it = '{default: 0};
        it.b0 = $urandom();
        it.b1 = $urandom();
        it.b2 = $urandom();
        it.a1 = $urandom();
        it.a2 = $urandom();
        it.ch = 1'($urandom_range(1));
        it.eob = ($urandom_range(7) == 0);
        it.band = BAND_W'($urandom());
        it.smp = random_sample();
        n_on = 0;
        foreach (band_on[b]) n_on += band_on[b];
        r = $urandom_range(99);
        if (r < 2) begin
            it.kind = KIND_UNUSED;
        end else if (r < 10) begin
            if (n_on >= MAX_ACTIVE) begin
                it.kind = KIND_DISABLE;
                do it.band = BAND_W'($urandom()); while (!band_on[it.band]);
            end else begin
                it.kind = KIND_LOAD;
                r = $urandom_range(99);
                mode = (r < 80) ? 0 : (r < 95) ? 1 : 2;
                it.b0 = random_coef(mode);
                it.b1 = random_coef(mode);
                it.b2 = random_coef(mode);
                it.a1 = random_coef(mode);
                it.a2 = random_coef(mode);
            end
        end else if (r < 14) begin
            it.kind = KIND_DISABLE;
        end else begin
            it.kind = KIND_SAMPLE;
        end
        return it;
    endfunction

    // Offers one item, waits for the transfer, then updates the predictor.
    // Signals read right after the edge still hold their values from before it.
    task automatic send_item(input eq_item_t it);
        eq_sample_t res;
        int         gap;
        in_valid     <= 1'b1;
        kind         <= it.kind;
        channel      <= it.ch;
        sample_in    <= it.smp;
        band_index   <= it.band;
        coef_b0      <= it.b0;
        coef_b1      <= it.b1;
        coef_b2      <= it.b2;
        coef_a1      <= it.a1;
        coef_a2      <= it.a2;
        end_of_block <= it.eob;
        do @(posedge clk); while (!in_ready);
        if (filter_item(it, res)) begin
            if (it.typed) begin
                if (res.smp !== it.typed_smp)
                    report_mismatch("predicted sample", res.smp, it.typed_smp);
                if (res.clip !== it.typed_clip)
                    report_mismatch("predicted clip flag", res.clip, it.typed_clip);
            end
            pending_samples.push_back(res);
        end
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request so that the
    // output register stays full and the block has to stop taking input.
    initial begin
        int gap;
        out_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_request) begin
                out_ready <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            gap = idle_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Compare every output transfer with the oldest predicted sample.
    always @(posedge clk) begin
        eq_sample_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("outstanding sample count", 1, 0);
            end else begin
                want = pending_samples.pop_front();
                if (sample_out !== want.smp) report_mismatch("sample_out", sample_out, want.smp);
                if (channel_out !== want.ch) report_mismatch("channel_out", channel_out, want.ch);
                if (block_end_out !== want.eob)
                    report_mismatch("block_end_out", block_end_out, want.eob);
                if (clipped !== want.clip) report_mismatch("clipped", clipped, want.clip);
            end
        end
    end

    initial begin
        #80_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        errors = 0;
        hold_request = 1'b0;
        foreach (band_on[b]) begin
            band_on[b] = 1'b0;
            shadow_b0[b] = '0;
            shadow_b1[b] = '0;
            shadow_b2[b] = '0;
            shadow_a1[b] = '0;
            shadow_a2[b] = '0;
            for (int c = 0; c < 2; c++) begin
                shadow_z1[c][b] = '0;
                shadow_z2[c][b] = '0;
            end
        end
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_SAMPLE;
        channel      = 1'b0;
        sample_in    = '0;
        band_index   = '0;
        coef_b0      = '0;
        coef_b1      = '0;
        coef_b2      = '0;
        coef_a1      = '0;
        coef_a2      = '0;
        end_of_block = 1'b0;

        // With no active band a sample passes unchanged; an unused kind is
        // dropped. A unity band leaves the sample alone, and a band at full
        // scale gain pins the output to the rails with the clip flag set.
        add_row(KIND_SAMPLE, 0, 24'sh7F_FFFF, 0, 0, 0, 0, 0, 0, 0, 1, 24'sh7F_FFFF, 0);
        add_row(KIND_SAMPLE, 1, 24'sh80_0000, 0, 0, 0, 0, 0, 0, 1, 1, 24'sh80_0000, 0);
        add_row(KIND_SAMPLE, 0, 24'sh00_0000, 0, 0, 0, 0, 0, 0, 0, 1, 24'sh00_0000, 0);
        add_row(KIND_UNUSED, 1, 24'sh12_3456, 7, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_LOAD, 0, 0, 0, 32'sh0400_0000, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 24'sh12_3456, 0, 0, 0, 0, 0, 0, 0, 1, 24'sh12_3456, 0);
        add_row(KIND_SAMPLE, 1, 24'shED_CBA9, 0, 0, 0, 0, 0, 0, 1, 1, 24'shED_CBA9, 0);
        add_row(KIND_LOAD, 0, 0, 63, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 24'sh7F_FFFF, 0, 0, 0, 0, 0, 0, 0, 1, 24'sh7F_FFFF, 1);
        add_row(KIND_SAMPLE, 0, 24'sh80_0000, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 24'sh40_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_LOAD, 0, 0, 63, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 1, 24'sh7F_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 1, 24'sh80_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 1, 24'sh00_0001, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_DISABLE, 1, 0, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 1, 24'sh55_5555, 0, 0, 0, 0, 0, 0, 0, 1, 24'sh55_5555, 0);
        add_row(KIND_LOAD, 0, 0, 31, 32'sh0200_0000, 32'sh0100_0000, 32'sh0080_0000,
                32'shFE00_0000, 32'sh0100_0000, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 24'sh2A_AAAA, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 24'shD5_5556, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_DISABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_DISABLE, 0, 0, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 24'sh65_4321, 0, 0, 0, 0, 0, 0, 0, 1, 24'sh65_4321, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_items[i]) send_item(directed_items[i]);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // Long receiver hold-off while items keep coming, and later one
            // pause that lets every outstanding sample drain first.
            if (n == 300) hold_request = 1'b1;
            if (n == 600) begin
                in_valid <= 1'b0;
                wait (pending_samples.size() == 0);
                @(posedge clk);
            end
            send_item(random_item());
        end
        in_valid <= 1'b0;

        wait (pending_samples.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/sbq_pkg.sv
design/sbq_mac.sv
design/sbq_store.sv
design/stereo_biquad_cascade_eq.sv
design/sbq_checker.sv
tb/testbench.sv
